// ----- src/pwmcap_pkg.sv -----
// ----------------------------------------------------------------------------
// pwmcap_pkg: shared types and constants for dual PWM input capture
// Field widths, configuration codes and per-channel state layout.
// ----------------------------------------------------------------------------
package pwmcap_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam int TS_W         = 32;
    localparam int CFG_IDX_W    = 1;

    localparam logic [TS_W-1:0] PERIOD_MIN_RST = 32'd1;
    localparam logic [TS_W-1:0] PERIOD_MAX_RST = 32'hFFFF_FFFF;

    typedef enum logic [0:0] {
        OP_EDGE = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD_MIN = 1'b0,
        REG_PERIOD_MAX = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [TS_W-1:0] period_min;
        logic [TS_W-1:0] period_max;
    } t_cfg;

    typedef struct packed {
        logic            operation;
        logic            channel;
        logic            level;
        logic [TS_W-1:0] timestamp_us;
    } t_item;

    typedef struct packed {
        logic [TS_W-1:0] period;
        logic [TS_W-1:0] high_time;
        logic            valid_flag;
        logic            fresh_flag;
        logic [TS_W-1:0] edge_cnt;
        logic [TS_W-1:0] period_rej;
        logic [TS_W-1:0] pulse_rej;
        logic [TS_W-1:0] edge_time;
        logic [TS_W-1:0] rise_time;
        logic [TS_W-1:0] fall_time;
        logic [TS_W-1:0] valid_time;
    } t_chan_state;

endpackage

// ----- src/pwmcap_item_if.sv -----
// ----------------------------------------------------------------------------
// pwmcap_item_if: input item channel
// Edge event or snapshot read, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pwmcap_item_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic        channel;
    logic        level;
    logic [31:0] timestamp_us;

    modport source (output valid, operation, channel, level, timestamp_us, input ready);
    modport sink   (input valid, operation, channel, level, timestamp_us, output ready);
endinterface

// ----- src/pwmcap_result_if.sv -----
// ----------------------------------------------------------------------------
// pwmcap_result_if: result channel
// One channel snapshot per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pwmcap_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] period;
    logic [31:0] high_time;
    logic        sample_valid;
    logic        fresh_sample;
    logic [31:0] edges_seen;
    logic [31:0] periods_rejected;
    logic [31:0] pulses_rejected;
    logic [31:0] edge_stamp;
    logic [31:0] rise_stamp;
    logic [31:0] fall_stamp;
    logic [31:0] valid_stamp;
    logic        result_channel;

    modport source (
        output valid, period, high_time, sample_valid, fresh_sample, edges_seen,
               periods_rejected, pulses_rejected, edge_stamp, rise_stamp,
               fall_stamp, valid_stamp, result_channel,
        input  ready
    );
    modport sink (
        input  valid, period, high_time, sample_valid, fresh_sample, edges_seen,
               periods_rejected, pulses_rejected, edge_stamp, rise_stamp,
               fall_stamp, valid_stamp, result_channel,
        output ready
    );
endinterface

// ----- src/pwmcap_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pwmcap_cfg_regs: period window registers
// Write-only register file holding the accepted period window.
// ----------------------------------------------------------------------------
module pwmcap_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [pwmcap_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [pwmcap_pkg::TS_W-1:0]       i_data,
    output pwmcap_pkg::t_cfg                  o_cfg
);
    import pwmcap_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (t_cfg_reg'(i_index))
                REG_PERIOD_MIN: n_cfg.period_min = i_data;
                REG_PERIOD_MAX: n_cfg.period_max = i_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_min <= PERIOD_MIN_RST;
            r_cfg.period_max <= PERIOD_MAX_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/pwmcap_edge_unit.sv -----
// ----------------------------------------------------------------------------
// pwmcap_edge_unit: per-item channel state update
// Applies one edge or read to a channel's state; gives snapshot and write-back.
// ----------------------------------------------------------------------------
module pwmcap_edge_unit (
    input  pwmcap_pkg::t_item       i_item,
    input  pwmcap_pkg::t_cfg        i_cfg,
    input  pwmcap_pkg::t_chan_state i_cur,
    output pwmcap_pkg::t_chan_state o_snap,
    output pwmcap_pkg::t_chan_state o_store
);
    import pwmcap_pkg::*;

    logic [TS_W-1:0] w_span;
    logic            w_has_rise;
    logic            w_in_window;
    logic            w_pulse_ok;
    t_chan_state     w_nxt;

    // wraps mod 2^32
    assign w_span      = i_item.timestamp_us - i_cur.rise_time;
    assign w_has_rise  = (i_cur.rise_time != '0);
    assign w_in_window = (w_span >= i_cfg.period_min) && (w_span <= i_cfg.period_max);
    assign w_pulse_ok  = (w_span != '0) && (w_span < i_cur.period);

    always_comb begin
        w_nxt = i_cur;
        if (t_op'(i_item.operation) == OP_EDGE) begin
            w_nxt.edge_time = i_item.timestamp_us;
            w_nxt.edge_cnt  = i_cur.edge_cnt + 32'd1;
            if (i_item.level) begin
                if (w_has_rise) begin
                    if (w_in_window) begin
                        w_nxt.period = w_span;
                    end else begin
                        w_nxt.period_rej = i_cur.period_rej + 32'd1;
                    end
                end
                w_nxt.rise_time = i_item.timestamp_us;
            end else if (w_has_rise && (i_cur.period != '0)) begin
                if (w_pulse_ok) begin
                    w_nxt.fall_time  = i_item.timestamp_us;
                    w_nxt.high_time  = w_span;
                    w_nxt.valid_time = i_item.timestamp_us;
                    w_nxt.valid_flag = 1'b1;
                    w_nxt.fresh_flag = 1'b1;
                end else begin
                    w_nxt.pulse_rej = i_cur.pulse_rej + 32'd1;
                end
            end
        end
    end

    // a read reports the flag, then clears it
    always_comb begin
        o_store = w_nxt;
        if (t_op'(i_item.operation) == OP_READ) begin
            o_store.fresh_flag = 1'b0;
        end
    end

    assign o_snap = w_nxt;

endmodule

// ----- src/dual_pwm_input_capture.sv -----
// ----------------------------------------------------------------------------
// dual_pwm_input_capture: two-channel PWM period / high-time capture
// Measures rise-to-rise period and high time per channel from edge beats and
// returns a channel snapshot for every beat.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Handshake           Beat contents
//  i_item     in   valid/ready         operation, channel, level, timestamp_us
//  o_result   out  valid/ready         channel snapshot (period ... stamps)
//  i_cfg_*    in   write enable only   register index, 32-bit data
//
//  Throughput: one beat per clock while o_result is ready; a beat passes the
//  input register, then the state update into the result register.
//  The per-channel state is read and written in the same cycle as the update,
//  so back-to-back beats on one channel see each other's effect.
//  Reset: synchronous, active low; clears all channel state, loads the
//  period window to [1, 0xFFFFFFFF] and empties both pipeline registers.
//  Stalls: while o_result is held, the input register still fills; ready
//  drops only when both registers hold beats.
// ----------------------------------------------------------------------------
module dual_pwm_input_capture (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pwmcap_item_if.sink                      i_item,
    pwmcap_result_if.source                  o_result,
    input  logic                             i_cfg_we,
    input  logic [pwmcap_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pwmcap_pkg::TS_W-1:0]      i_cfg_data
);
    import pwmcap_pkg::*;

    // Config window
    t_cfg w_cfg;

    pwmcap_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // Result register
    logic        r_out_valid;
    t_chan_state r_out_snap;
    logic        r_out_channel;

    // Input register
    logic  r_in_valid;
    t_item r_in;
    logic  w_advance;
    logic  w_in_take;

    assign w_advance = r_in_valid && (!r_out_valid || o_result.ready);
    assign w_in_take = i_item.valid && i_item.ready;
    assign i_item.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.operation    <= i_item.operation;
            r_in.channel      <= i_item.channel;
            r_in.level        <= i_item.level;
            r_in.timestamp_us <= i_item.timestamp_us;
        end
    end

    // Per-channel state: 290 flops per channel, reset to zero
    t_chan_state r_chan [NUM_CHANNELS];
    t_chan_state w_cur;
    t_chan_state w_snap;
    t_chan_state w_store;
    logic        w_present;

    // channel numbers beyond the built channels are ignored
    assign w_present = (32'(r_in.channel) < 32'(NUM_CHANNELS));
    assign w_cur     = w_present ? r_chan[r_in.channel] : '0;

    pwmcap_edge_unit u_edge (
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .i_cur   (w_cur),
        .o_snap  (w_snap),
        .o_store (w_store)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_chan[k] <= '0;
            end
        end else if (w_advance && w_present) begin
            r_chan[r_in.channel] <= w_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_snap    <= w_present ? w_snap : '0;
            r_out_channel <= r_in.channel;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.period           = r_out_snap.period;
    assign o_result.high_time        = r_out_snap.high_time;
    assign o_result.sample_valid     = r_out_snap.valid_flag;
    assign o_result.fresh_sample     = r_out_snap.fresh_flag;
    assign o_result.edges_seen       = r_out_snap.edge_cnt;
    assign o_result.periods_rejected = r_out_snap.period_rej;
    assign o_result.pulses_rejected  = r_out_snap.pulse_rej;
    assign o_result.edge_stamp       = r_out_snap.edge_time;
    assign o_result.rise_stamp       = r_out_snap.rise_time;
    assign o_result.fall_stamp       = r_out_snap.fall_time;
    assign o_result.valid_stamp      = r_out_snap.valid_time;
    assign o_result.result_channel   = r_out_channel;

endmodule

// ----- test/capture_checker.sv -----
// ----------------------------------------------------------------------------
// capture_checker: snapshot predictor and scoreboard for PWM capture
// Follows the window registers and every accepted edge/read beat, keeps its
// own per-channel capture state and compares each result beat with it.
// ----------------------------------------------------------------------------
module capture_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pwmcap_item_if                      item_bus,
    pwmcap_result_if                    result_bus,
    input  logic                        i_cfg_we,
    input  logic [pwmcap_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pwmcap_pkg::TS_W-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_outstanding
);
    import pwmcap_pkg::*;

    typedef struct packed {
        t_chan_state chan;
        logic        channel;
    } t_snapshot;

    t_chan_state     chan_regs [NUM_CHANNELS];
    logic [TS_W-1:0] win_min;
    logic [TS_W-1:0] win_max;
    t_snapshot       snapshot_q [$];
    int              fail_count = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = snapshot_q.size();

    // Updates the channel state for one beat and returns the snapshot it reports.
    function automatic t_snapshot capture_beat(input t_item beat);
        t_chan_state     st;
        t_snapshot       snap;
        logic [TS_W-1:0] span;
        st   = chan_regs[beat.channel];
        span = beat.timestamp_us - st.rise_time;
        if (t_op'(beat.operation) == OP_EDGE) begin
            st.edge_time = beat.timestamp_us;
            st.edge_cnt  = st.edge_cnt + 1'b1;
            if (beat.level) begin
                // rise stamp 0 means no earlier rise: nothing to measure
                if (st.rise_time != '0) begin
                    if (span >= win_min && span <= win_max)
                        st.period = span;
                    else
                        st.period_rej = st.period_rej + 1'b1;
                end
                st.rise_time = beat.timestamp_us;
            end else if (st.rise_time != '0 && st.period != '0) begin
                if (span != '0 && span < st.period) begin
                    st.fall_time  = beat.timestamp_us;
                    st.high_time  = span;
                    st.valid_time = beat.timestamp_us;
                    st.valid_flag = 1'b1;
                    st.fresh_flag = 1'b1;
                end else begin
                    st.pulse_rej = st.pulse_rej + 1'b1;
                end
            end
        end
        snap.chan    = st;
        snap.channel = beat.channel;
        // a read reports the fresh flag first, then clears it
        if (t_op'(beat.operation) == OP_READ)
            st.fresh_flag = 1'b0;
        chan_regs[beat.channel] = st;
        return snap;
    endfunction

    task automatic check_field(input string name, input logic [TS_W-1:0] want,
                               input logic [TS_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_item     beat;
        t_snapshot want;
        if (!i_rst_n) begin
            foreach (chan_regs[c])
                chan_regs[c] = '0;
            win_min = PERIOD_MIN_RST;
            win_max = PERIOD_MAX_RST;
            snapshot_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_PERIOD_MIN: win_min = i_cfg_data;
                    REG_PERIOD_MAX: win_max = i_cfg_data;
                    default: ;
                endcase
            end
            if (item_bus.valid && item_bus.ready) begin
                beat.operation    = item_bus.operation;
                beat.channel      = item_bus.channel;
                beat.level        = item_bus.level;
                beat.timestamp_us = item_bus.timestamp_us;
                snapshot_q.push_back(capture_beat(beat));
            end
            if (result_bus.valid && result_bus.ready) begin
                if (snapshot_q.size() == 0) begin
                    $display("%0t: result beat, expected none, actual channel %0d period %h",
                             $time, result_bus.result_channel, result_bus.period);
                    fail_count++;
                end else begin
                    want = snapshot_q.pop_front();
                    check_field("period", want.chan.period, result_bus.period);
                    check_field("high_time", want.chan.high_time, result_bus.high_time);
                    check_field("sample_valid", TS_W'(want.chan.valid_flag),
                                TS_W'(result_bus.sample_valid));
                    check_field("fresh_sample", TS_W'(want.chan.fresh_flag),
                                TS_W'(result_bus.fresh_sample));
                    check_field("edges_seen", want.chan.edge_cnt, result_bus.edges_seen);
                    check_field("periods_rejected", want.chan.period_rej,
                                result_bus.periods_rejected);
                    check_field("pulses_rejected", want.chan.pulse_rej,
                                result_bus.pulses_rejected);
                    check_field("edge_stamp", want.chan.edge_time, result_bus.edge_stamp);
                    check_field("rise_stamp", want.chan.rise_time, result_bus.rise_stamp);
                    check_field("fall_stamp", want.chan.fall_time, result_bus.fall_stamp);
                    check_field("valid_stamp", want.chan.valid_time, result_bus.valid_stamp);
                    check_field("result_channel", TS_W'(want.channel),
                                TS_W'(result_bus.result_channel));
                end
            end
        end
    end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: dual_pwm_input_capture verification top
// Drives edge and read beats plus window writes, with random idling on both
// channels; capture_checker predicts and scores every result beat.
// ----------------------------------------------------------------------------
module testbench;
    import pwmcap_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;   // long result back-pressure stretch
    localparam int PHASE_BEATS  = 110;   // random beats per window setting
    localparam bit RISE         = 1'b1;
    localparam bit FALL         = 1'b0;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_we = 1'b0;
    t_cfg_reg        cfg_index = REG_PERIOD_MIN;
    logic [TS_W-1:0] cfg_data = '0;
    int              fail_count;
    int              outstanding;

    // stimulus control shared between the beat source and the ready driver
    bit              calm = 1'b0;      // no idling at all in the last phase
    bit              hold_req = 1'b0;  // asks the ready driver for a long stall

    // per-channel waveform generator: last planned rise, nominal period,
    // period of the current cycle and which edge comes next
    logic [TS_W-1:0] rise_at [NUM_CHANNELS];
    logic [TS_W-1:0] nominal [NUM_CHANNELS];
    logic [TS_W-1:0] cur_p   [NUM_CHANNELS];
    bit              next_rise [NUM_CHANNELS];

    pwmcap_item_if   item_bus ();
    pwmcap_result_if result_bus ();

    dual_pwm_input_capture DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_item      (item_bus),
        .o_result    (result_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    capture_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .item_bus      (item_bus),
        .result_bus    (result_bus),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offers one beat at the current falling edge and holds it until taken.
    // Returns on a falling edge; sometimes inserts an idle burst afterwards.
    task automatic send_beat(input t_op op, input logic ch, input logic lvl,
                             input logic [TS_W-1:0] ts);
        item_bus.valid        <= 1'b1;
        item_bus.operation    <= op;
        item_bus.channel      <= ch;
        item_bus.level        <= lvl;
        item_bus.timestamp_us <= ts;
        do
            @(posedge clk);
        while (!(item_bus.valid && item_bus.ready));
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
    endtask

    // Stops offering and waits until every result beat has come back.
    task automatic drain_results();
        item_bus.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Both window registers, back to back; only called with the block idle.
    task automatic write_window(input logic [TS_W-1:0] lo, input logic [TS_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PERIOD_MIN;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= REG_PERIOD_MAX;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly well-formed rise/fall trains per channel with random content;
    // the rest are reads and stray edges with random level and stamp.
    task automatic random_beat(input logic [TS_W-1:0] gen_lo, input logic [TS_W-1:0] gen_hi);
        logic            ch;
        int              pick;
        t_op             op;
        logic            lvl;
        logic [TS_W-1:0] ts;
        logic [TS_W-1:0] p;
        logic [TS_W-1:0] hi;
        ch   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        op   = OP_EDGE;
        lvl  = 1'($urandom_range(0, 1));
        ts   = $urandom;
        if (pick < 15) begin
            op = OP_READ;
        end else if (pick >= 22) begin
            if (next_rise[ch]) begin
                case ($urandom_range(0, 9))
                    0:       p = $urandom_range(gen_lo, gen_hi);
                    1:       p = nominal[ch] + $urandom_range(0, 4) - 2;
                    default: p = nominal[ch];
                endcase
                rise_at[ch] = rise_at[ch] + p;
                cur_p[ch]   = p;
                ts          = rise_at[ch];
                lvl         = RISE;
            end else begin
                // high time mostly inside the period, sometimes zero, on or past it
                case ($urandom_range(0, 9))
                    0:       hi = '0;
                    1:       hi = cur_p[ch];
                    2:       hi = cur_p[ch] + $urandom_range(1, 50);
                    default: hi = (cur_p[ch] > 1) ? $urandom_range(1, cur_p[ch] - 1) : 1;
                endcase
                ts  = rise_at[ch] + hi;
                lvl = FALL;
            end
            next_rise[ch] = !next_rise[ch];
        end
        send_beat(op, ch, lvl, ts);
    endtask

    // One window setting: settle, reprogram, then a burst of random beats.
    task automatic run_phase(input logic [TS_W-1:0] win_lo, input logic [TS_W-1:0] win_hi,
                             input logic [TS_W-1:0] gen_lo, input logic [TS_W-1:0] gen_hi,
                             input bit with_hold);
        drain_results();
        write_window(win_lo, win_hi);
        foreach (nominal[c])
            nominal[c] = $urandom_range(gen_lo, gen_hi);
        for (int n = 0; n < PHASE_BEATS; n++) begin
            // long result stall while beats keep coming, so the block backs up
            if (with_hold && n == 40)
                hold_req = 1'b1;
            random_beat(gen_lo, gen_hi);
        end
    endtask

    // Result ready: random stall bursts, runs of steady ready, one long hold.
    initial begin
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end else begin
                result_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge clk);
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("dual_pwm_input_capture test failed");
        $finish;
    end

    initial begin
        item_bus.valid        = 1'b0;
        item_bus.operation    = OP_EDGE;
        item_bus.channel      = 1'b0;
        item_bus.level        = 1'b0;
        item_bus.timestamp_us = '0;
        foreach (rise_at[c]) begin
            rise_at[c]   = $urandom;
            nominal[c]   = 32'd1000;
            cur_p[c]     = 32'd1000;
            next_rise[c] = 1'b1;
        end

        // reset held, then released on a falling edge
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed: reset window [1, max] ----
        // read of a fresh channel; level and stamp are don't-care on reads
        send_beat(OP_READ, 1'b0, RISE, 32'hFFFF_FFFF);
        // fall with no rise yet: only the edge count and stamp move
        send_beat(OP_EDGE, 1'b0, FALL, 32'd5);
        // rise at stamp 0 keeps "no rise", so the next rise measures nothing
        send_beat(OP_EDGE, 1'b0, RISE, 32'd0);
        send_beat(OP_EDGE, 1'b0, RISE, 32'd100);
        // fall with a rise but no period yet
        send_beat(OP_EDGE, 1'b0, FALL, 32'd130);
        send_beat(OP_EDGE, 1'b0, RISE, 32'd1100);
        // zero high time, then high time equal to the period: both rejected
        send_beat(OP_EDGE, 1'b0, FALL, 32'd1100);
        send_beat(OP_EDGE, 1'b0, RISE, 32'd2100);
        send_beat(OP_EDGE, 1'b0, FALL, 32'd3100);
        send_beat(OP_EDGE, 1'b0, FALL, 32'd2400);
        // first read returns fresh set and clears it, second sees it clear
        send_beat(OP_READ, 1'b0, FALL, 32'd0);
        send_beat(OP_READ, 1'b0, RISE, 32'h5A5A_5A5A);
        // channel 1: period across the stamp wrap, then a zero-length period
        // below the minimum and a fall stamp that wraps past the period
        send_beat(OP_EDGE, 1'b1, RISE, 32'hFFFF_FF00);
        send_beat(OP_EDGE, 1'b1, RISE, 32'h0000_0100);
        send_beat(OP_EDGE, 1'b1, FALL, 32'h0000_0180);
        send_beat(OP_EDGE, 1'b1, RISE, 32'h0000_0100);
        send_beat(OP_EDGE, 1'b1, FALL, 32'h0000_0050);
        send_beat(OP_READ, 1'b1, RISE, 32'hFFFF_FFFF);

        // empty window: min above max rejects every period
        drain_results();
        write_window(32'hFFFF_FFFF, 32'd0);
        send_beat(OP_EDGE, 1'b0, RISE, 32'd5000);
        send_beat(OP_EDGE, 1'b1, RISE, 32'h0000_0300);

        // full window from 0: a zero period is accepted, and a later fall
        // then has no usable period
        drain_results();
        write_window(32'd0, 32'hFFFF_FFFF);
        send_beat(OP_EDGE, 1'b0, RISE, 32'd5000);
        send_beat(OP_EDGE, 1'b0, FALL, 32'd5100);

        // window pinned at the top: only the largest possible period passes
        drain_results();
        write_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(OP_EDGE, 1'b0, RISE, 32'd4999);
        send_beat(OP_EDGE, 1'b0, FALL, 32'd5000);
        send_beat(OP_READ, 1'b0, FALL, 32'd0);

        // ---- random phases, one window setting each ----
        run_phase(32'd1, 32'hFFFF_FFFF, 32'd2, 32'd5000, 1'b1);
        run_phase(32'd500, 32'd2000, 32'd400, 32'd2200, 1'b0);
        run_phase(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd3000, 1'b0);
        run_phase(32'd1000, 32'd1000, 32'd1000, 32'd1000, 1'b0);
        run_phase(32'hFFF8_0000, 32'hFFFF_FFFF, 32'hFFF0_0000, 32'hFFFF_FFFF, 1'b0);
        // last part runs flat out on both sides
        drain_results();
        calm = 1'b1;
        run_phase(32'd3000, 32'd100, 32'd50, 32'd4000, 1'b0);

        // everything sent: wait out the results and the two-stage pipeline
        drain_results();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("dual_pwm_input_capture test passed");
        else
            $display("dual_pwm_input_capture test failed");
        $finish;
    end

endmodule
